// File: hw/rtl/sliding_window_min_max_top_macros.svh
// Assertion macros for the sliding window min/max block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SLIDING_WINDOW_MIN_MAX_TOP_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SWMM_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("swmm assertion failed");
`define SWMM_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("swmm assertion failed");
`else
`define SWMM_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define SWMM_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

// File: hw/rtl/swmm_pkg.sv
// Shared constants and control types for the sliding window min/max block.
// No dependencies; used by swmm_deque and sliding_window_min_max_top.
package swmm_pkg;

  localparam int WINDOW_MAX_DEF   = 1024;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int CFG_W            = 11;

  // command from the top level to each deque
  typedef struct packed {
    logic start;
    logic last;
  } swmm_ctl_t;

  // deque status back to the top level
  typedef struct packed {
    logic busy;
    logic done;
  } swmm_sts_t;

endpackage

// File: hw/rtl/sliding_window_min_max_top.sv
// Sliding window min/max: for each word, each deque retires expired entries from its front
// and then pops dominated entries from its back (one memory step per cycle on each deque,
// both deques in parallel); each deque removes at most one entry per word on average.
// The input is not ready while a word is in progress; it is ready again once the result is
// in the output register, or once both deques are done with a word that gives no result.
// rst_ni clears control state and sets the window to 1; deque memories need no clearing pass.
`include "sliding_window_min_max_top_macros.svh"

module sliding_window_min_max_top
  import swmm_pkg::*;
#(
  parameter  int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter  int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int IN_W         = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W        = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,   // window_size
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // sample, zero pad
  input  logic             s_axis_tlast,  // last_sample
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // window_min, window_max, zero pad
  output logic             m_axis_tlast   // sequence_end
);

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int PW = $clog2(2 * WINDOW_MAX);
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0]        cfg_q;
  logic [EW-1:0]           cfg_ext;
  logic [CW-1:0]           ws_eff;

  logic                    busy_q;
  logic                    last_q;
  logic [PW-1:0]           pos_q;
  logic [CW-1:0]           filled_q;
  logic                    out_vld_q;
  logic [SAMPLE_WIDTH-1:0] out_min_q, out_max_q;
  logic                    out_last_q;

  logic                    in_acc;
  logic                    fin_rdy, fin, emit;
  logic [CW-1:0]           filled_nx;
  logic [PW-1:0]           pos_nx;

  swmm_ctl_t               dq_ctl;
  swmm_sts_t               min_sts, max_sts;
  logic [SAMPLE_WIDTH-1:0] min_front, max_front;

  // zero means one, anything above the depth saturates
  always_comb begin
    cfg_ext = EW'(cfg_q);
    if (cfg_ext == '0) begin
      ws_eff = CW'(1);
    end else if (cfg_ext > EW'(WINDOW_MAX)) begin
      ws_eff = CW'(WINDOW_MAX);
    end else begin
      ws_eff = cfg_ext[CW-1:0];
    end
  end

  assign s_axis_tready = !busy_q;
  assign in_acc        = s_axis_tvalid && !busy_q;

  assign dq_ctl.start = in_acc;
  assign dq_ctl.last  = s_axis_tlast;

  swmm_deque #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .IS_MAX      (1'b0)
  ) u_min (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dq_ctl),
    .val_i  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .now_i  (pos_q),
    .ws_i   (ws_eff),
    .sts_o  (min_sts),
    .front_o(min_front)
  );

  swmm_deque #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .IS_MAX      (1'b1)
  ) u_max (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dq_ctl),
    .val_i  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .now_i  (pos_q),
    .ws_i   (ws_eff),
    .sts_o  (max_sts),
    .front_o(max_front)
  );

  assign filled_nx = (filled_q < ws_eff) ? filled_q + CW'(1) : ws_eff;
  assign emit      = (filled_nx == ws_eff);
  assign pos_nx    = (pos_q == PW'(2 * WINDOW_MAX - 1)) ? '0 : pos_q + PW'(1);
  assign fin_rdy   = busy_q && !min_sts.busy && !max_sts.busy;
  assign fin       = fin_rdy && (!emit || !out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= CFG_W'(1);
      busy_q    <= 1'b0;
      last_q    <= 1'b0;
      pos_q     <= '0;
      filled_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        busy_q <= 1'b1;
        last_q <= s_axis_tlast;
      end else if (fin) begin
        busy_q <= 1'b0;
        if (last_q) begin
          pos_q    <= '0;
          filled_q <= '0;
        end else begin
          pos_q    <= pos_nx;
          filled_q <= filled_nx;
        end
      end
      if (fin && emit) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin && emit) begin
      out_min_q  <= min_front;
      out_max_q  <= max_front;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'({out_max_q, out_min_q});
  assign m_axis_tlast  = out_last_q;

  `SWMM_ASSERT_NXT(a_deq_run, clk_i, rst_ni, in_acc, min_sts.busy && max_sts.busy)
  `SWMM_ASSERT_IMPL(a_no_overrun, clk_i, rst_ni, fin && emit, !out_vld_q || m_axis_tready)
  `SWMM_ASSERT_IMPL(a_done_busy, clk_i, rst_ni, min_sts.done || max_sts.done, busy_q)

endmodule

// File: hw/rtl/swmm_deque.sv
// One monotonic deque (min or max) held in a two-read-port synchronous memory.
// Depends on swmm_pkg and sliding_window_min_max_top_macros.svh.
`include "sliding_window_min_max_top_macros.svh"

module swmm_deque
  import swmm_pkg::*;
#(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter bit IS_MAX       = 1'b0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  swmm_ctl_t                           ctl_i,
  input  logic [SAMPLE_WIDTH-1:0]             val_i,
  input  logic [$clog2(2*WINDOW_MAX)-1:0]     now_i,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]     ws_i,
  output swmm_sts_t                           sts_o,
  output logic [SAMPLE_WIDTH-1:0]             front_o
);

  localparam int HW   = $clog2(WINDOW_MAX);
  localparam int CW   = $clog2(WINDOW_MAX + 1);
  localparam int PW   = $clog2(2 * WINDOW_MAX);
  localparam int SPAN = 2 * WINDOW_MAX;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RETIRE,
    ST_POP
  } state_e;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] val;
    logic [PW-1:0]           pos;
  } ent_t;

  function automatic logic [HW-1:0] inc_idx(input logic [HW-1:0] i);
    if (i == HW'(WINDOW_MAX - 1)) return '0;
    return i + HW'(1);
  endfunction

  function automatic logic [HW-1:0] dec_idx(input logic [HW-1:0] i);
    if (i == '0) return HW'(WINDOW_MAX - 1);
    return i - HW'(1);
  endfunction

  ent_t mem [WINDOW_MAX];
  ent_t rd_a, rd_b;

  state_e                  state_q, state_d;
  logic [HW-1:0]           head_q, head_d;
  logic [HW-1:0]           bk_q, bk_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [SAMPLE_WIDTH-1:0] front_q, front_d;
  logic                    done_q, done_d;

  logic [SAMPLE_WIDTH-1:0] val_q;
  logic [PW-1:0]           now_q;
  logic [CW-1:0]           ws_q;
  logic                    last_q;

  logic                    we;
  logic [HW-1:0]           waddr;
  logic [PW:0]             age_a;
  logic                    pop_hit;
  logic [PW:0]             tail_sum;
  logic [HW-1:0]           exp_bk;

  // age of the front entry, positions wrap modulo twice the window depth
  always_comb begin
    if (now_q >= rd_a.pos) begin
      age_a = {1'b0, now_q} - {1'b0, rd_a.pos};
    end else begin
      age_a = {1'b0, now_q} + (PW+1)'(SPAN) - {1'b0, rd_a.pos};
    end
  end

  // equal entries go too
  assign pop_hit = IS_MAX ? ($signed(rd_b.val) <= $signed(val_q))
                          : ($signed(rd_b.val) >= $signed(val_q));

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    bk_d    = bk_q;
    cnt_d   = cnt_q;
    front_d = front_q;
    done_d  = 1'b0;
    we      = 1'b0;
    waddr   = inc_idx(bk_q);
    case (state_q)
      ST_IDLE: begin
        if (ctl_i.start) begin
          state_d = ST_RETIRE;
        end
      end
      ST_RETIRE: begin
        if (cnt_q != '0 && age_a >= (PW+1)'(ws_q)) begin
          head_d = inc_idx(head_q);
          cnt_d  = cnt_q - CW'(1);
        end else begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (cnt_q != '0 && pop_hit) begin
          bk_d  = dec_idx(bk_q);
          cnt_d = cnt_q - CW'(1);
        end else begin
          we      = 1'b1;
          front_d = (cnt_q == '0) ? val_q : rd_a.val;
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (last_q) begin
            head_d = '0;
            bk_d   = HW'(WINDOW_MAX - 1);
            cnt_d  = '0;
          end else begin
            bk_d  = inc_idx(bk_q);
            cnt_d = cnt_q + CW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      bk_q    <= HW'(WINDOW_MAX - 1);
      cnt_q   <= '0;
      front_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      bk_q    <= bk_d;
      cnt_q   <= cnt_d;
      front_q <= front_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && ctl_i.start) begin
      val_q  <= val_i;
      now_q  <= now_i;
      ws_q   <= ws_i;
      last_q <= ctl_i.last;
    end
  end

  // front port follows the next head, back port the next back entry
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= '{val: val_q, pos: now_q};
    end
    rd_a <= mem[head_d];
    rd_b <= mem[bk_d];
  end

  assign sts_o.busy = (state_q != ST_IDLE);
  assign sts_o.done = done_q;
  assign front_o    = front_q;

  // back pointer must stay head + count - 1
  always_comb begin
    tail_sum = (PW+1)'(head_q) + (PW+1)'(cnt_q);
    if (tail_sum >= (PW+1)'(WINDOW_MAX)) begin
      tail_sum = tail_sum - (PW+1)'(WINDOW_MAX);
    end
    exp_bk = dec_idx(tail_sum[HW-1:0]);
  end

  `SWMM_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CW'(WINDOW_MAX))
  `SWMM_ASSERT_IMPL(a_ptr_sync, clk_i, rst_ni, 1'b1, bk_q == exp_bk)
  `SWMM_ASSERT_NXT(a_start_idle, clk_i, rst_ni, ctl_i.start, state_q == ST_RETIRE)

endmodule

// File: dv/tb.sv
// Testbench for sliding_window_min_max_top: directed and random sample streams checked
// against an in-bench monotonic-deque predictor. Depends on swmm_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb;
  import swmm_pkg::*;

  localparam int WIN_DEPTH   = WINDOW_MAX_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SAMPLE_MIN  = 32'sh8000_0000;
  localparam int SAMPLE_MAX  = 32'sh7FFF_FFFF;

  typedef struct {
    int         value;
    logic [10:0] pos;
  } cand_t;

  typedef struct {
    int   lo;
    int   hi;
    logic seq_end;
  } minmax_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata  = '0;  // sample
  logic             s_axis_tlast  = 1'b0;  // last_sample
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [63:0]      m_axis_tdata;  // window_min, window_max
  logic             m_axis_tlast;  // sequence_end

  // predictor state
  logic [10:0] window_cfg = 11'd1;
  cand_t       lo_cand_q[$];
  cand_t       hi_cand_q[$];
  logic [10:0] seq_pos    = '0;
  int          filled     = 0;
  minmax_t     pending_minmax_q[$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int err_count      = 0;
  int ramp_val       = 0;

  sliding_window_min_max_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic int window_eff();
    if (window_cfg == 0) return 1;
    if (window_cfg > WIN_DEPTH) return WIN_DEPTH;
    return int'(window_cfg);
  endfunction

  // worst case front retirements plus back pops, plus pipeline overhead
  function automatic int settle_cycles();
    return 2 * window_eff() + 16;
  endfunction

  function automatic void minmax_predict(input int s, input logic lst);
    int eff;
    minmax_t res;
    eff = window_eff();
    // drop candidates that slid out of the window (positions wrap at 2048)
    while (lo_cand_q.size() > 0 && ((seq_pos - lo_cand_q[0].pos) & 32'h7FF) >= eff)
      void'(lo_cand_q.pop_front());
    while (hi_cand_q.size() > 0 && ((seq_pos - hi_cand_q[0].pos) & 32'h7FF) >= eff)
      void'(hi_cand_q.pop_front());
    while (lo_cand_q.size() > 0 && lo_cand_q[$].value >= s) void'(lo_cand_q.pop_back());
    while (hi_cand_q.size() > 0 && hi_cand_q[$].value <= s) void'(hi_cand_q.pop_back());
    lo_cand_q.push_back('{s, seq_pos});
    hi_cand_q.push_back('{s, seq_pos});
    if (filled < eff) filled++;
    if (filled > eff) filled = eff;
    if (filled >= eff) begin
      res.lo      = lo_cand_q[0].value;
      res.hi      = hi_cand_q[0].value;
      res.seq_end = lst;
      pending_minmax_q.push_back(res);
    end
    seq_pos++;
    if (lst) begin
      lo_cand_q.delete();
      hi_cand_q.delete();
      seq_pos = '0;
      filled  = 0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got 0x%08h want 0x%08h", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    minmax_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_minmax_q.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[31:0], '0);
      end else begin
        want = pending_minmax_q.pop_front();
        if ($signed(m_axis_tdata[31:0]) != want.lo)
          report_mismatch("window_min", m_axis_tdata[31:0], want.lo);
        if ($signed(m_axis_tdata[63:32]) != want.hi)
          report_mismatch("window_max", m_axis_tdata[63:32], want.hi);
        if (m_axis_tlast != want.seq_end)
          report_mismatch("sequence_end", 32'(m_axis_tlast), 32'(want.seq_end));
      end
    end
  end

  // called at a falling edge; valid stays up after acceptance so back-to-back
  // words need no second assignment in one step
  task automatic send_sample(input int s, input logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    minmax_predict(s, lst);
    @(negedge clk_i);
  endtask

  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (pending_minmax_q.size() != 0) @(negedge clk_i);
    // a word with no result may still be in flight
    repeat (settle_cycles()) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [10:0] w);
    quiesce();
    cfg_wdata_i <= w;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    window_cfg = w;
  endtask

  function automatic logic [10:0] pick_window();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 11'($urandom_range(4, 1));
    if (r < 70) return 11'($urandom_range(16, 5));
    if (r < 90) return 11'($urandom_range(64, 17));
    if (r < 95) return 11'd0;
    return 11'($urandom_range(2047, 1000));
  endfunction

  function automatic int pick_length();
    int eff;
    eff = window_eff();
    if (eff > 64) return $urandom_range(20, 1);
    if ($urandom_range(9) == 0) return $urandom_range(eff, 1);
    return eff + $urandom_range(30, 0);
  endfunction

  function automatic int next_sample(input int style);
    case (style)
      0: return $urandom;
      1: return int'($urandom_range(8)) - 4;
      2: begin
        case ($urandom_range(3))
          0: return SAMPLE_MIN;
          1: return SAMPLE_MAX;
          2: return 0;
          default: return -1;
        endcase
      end
      default: begin
        if ($urandom_range(31) == 0) ramp_val = $urandom;
        else ramp_val = ramp_val + int'($urandom_range(20)) - 10;
        return ramp_val;
      end
    endcase
  endfunction

  // window of one after reset: each word is its own min and max
  task automatic test_reset_window();
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b1);
  endtask

  task automatic test_zero_window();
    write_window(11'd0);
    send_sample(123, 1'b0);
    send_sample(-456, 1'b1);
  endtask

  task automatic test_equal_and_extremes();
    write_window(11'd3);
    send_sample(7, 1'b0);
    send_sample(7, 1'b0);
    send_sample(7, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(-1, 1'b1);
  endtask

  // sequence ends before the window fills: no result, state still clears
  task automatic test_short_sequence();
    write_window(11'd1024);
    send_sample(5, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(0, 1'b1);
  endtask

  task automatic test_window_change();
    write_window(11'd4);
    for (int i = 0; i < 5; i++) send_sample(10 - 3 * i, 1'b0);
    write_window(11'd2);  // shrink: result right away
    send_sample(40, 1'b0);
    write_window(11'd5);  // growth: withheld until filled
    send_sample(-40, 1'b0);
    send_sample(3, 1'b0);
    send_sample(3, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
  endtask

  // full-depth deques and whole-deque back pops in one sequence
  task automatic test_full_window();
    int s;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_window(11'h7FF);
    for (int i = 0; i < 1100; i++) begin
      if (i < 1024) s = SAMPLE_MIN + 1 + i * 4000;
      else if (i == 1024) s = SAMPLE_MIN;
      else if (i < 1099) s = SAMPLE_MAX - 1 - (i - 1025) * 4000;
      else s = SAMPLE_MAX;
      send_sample(s, i == 1099);
    end
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                     input int n_items);
    int sent;
    int len;
    int style;
    int mid;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) write_window(pick_window());
      len   = pick_length();
      style = $urandom_range(3);
      mid   = ($urandom_range(3) == 0) ? $urandom_range(len - 1) : -1;
      for (int i = 0; i < len; i++) begin
        if (i == mid && i != 0) write_window(pick_window());
        send_sample(next_sample(style), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("sliding_window_min_max_top regression: fail");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_window();
    test_zero_window();
    test_equal_and_extremes();
    test_short_sequence();
    test_window_change();
    test_full_window();
    test_random_traffic(0, 0, 100);
    test_random_traffic(59, 0, 100);
    test_random_traffic(0, 59, 100);
    test_random_traffic(35, 35, 100);

    quiesce();
    if (err_count == 0) begin
      $display("sliding_window_min_max_top regression: pass");
    end else begin
      $display("sliding_window_min_max_top regression: fail");
    end
    $finish;
  end

endmodule
